[src/sm3_pkg.sv]
// sm3 hash engine package: constants, command and status types, round helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sm3_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };
  localparam word_t TJ_LOW  = 32'h79cc4519;
  localparam word_t TJ_HIGH = 32'h7a879d8a;
  localparam int unsigned ROUNDS = 64;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      capture;
    logic      put;
    byte_sel_t sel;
    logic [2:0] byte_k;
    logic      count;
    logic      load;
    logic      round;
    logic [5:0] round_idx;
    logic      final_xor;
    logic      restart;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic pos_wrap;
    logic pos_at55;
  } status_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

`default_nettype wire

[src/sm3_if.sv]
// valid/ready channel interfaces for message words and digest words
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;
  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_done;
  modport source (output valid, digest_word, word_index, digest_done, input ready);
  modport sink (input valid, digest_word, word_index, digest_done, output ready);
endinterface

`default_nettype wire

[src/sm3_datapath.sv]
// sm3 datapath: block buffer, byte counters, message schedule window, round registers
// depends on sm3_pkg
`timescale 1ns / 1ps
`default_nettype none

module sm3_datapath import sm3_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic [31:0] in_data,
  output status_t          st,
  output word_t            digest_word
);

  word_t       data_r;
  word_t       blk_r [16];
  word_t       win_r [16];
  word_t       cv_r  [8];
  word_t       a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [5:0]  pos_r;
  logic [60:0] msg_r;

  logic [7:0]  byte_v;
  logic [63:0] bits;
  word_t       ff, gg, tj, a12, ss1, ss2, tt1, tt2, wnew;

  assign bits = {msg_r, 3'b000};

  always_comb begin
    case (cmd.sel)
      SEL_DATA: byte_v = data_r[8*(3-cmd.byte_k[1:0]) +: 8];
      SEL_PAD:  byte_v = PAD_BYTE;
      SEL_ZERO: byte_v = 8'h00;
      SEL_LEN:  byte_v = bits[8*(7-cmd.byte_k) +: 8];
      default:  byte_v = 8'h00;
    endcase
  end

  assign st.pos_wrap = (pos_r == 6'd63);
  assign st.pos_at55 = (pos_r == 6'd55);
  assign digest_word = cv_r[cmd.out_idx];

  // one compression round
  always_comb begin
    if (cmd.round_idx < 6'd16) begin
      tj = TJ_LOW;
      ff = a_r ^ b_r ^ c_r;
      gg = e_r ^ f_r ^ g_r;
    end else begin
      tj = TJ_HIGH;
      ff = (a_r & b_r) | (a_r & c_r) | (b_r & c_r);
      gg = (e_r & f_r) | (~e_r & g_r);
    end
    a12  = rotl(a_r, 5'd12);
    ss1  = rotl(a12 + e_r + rotl(tj, cmd.round_idx[4:0]), 5'd7);
    ss2  = ss1 ^ a12;
    tt1  = ff + d_r + ss2 + (win_r[0] ^ win_r[4]);
    tt2  = gg + h_r + ss1 + win_r[0];
    wnew = perm1(win_r[0] ^ win_r[7] ^ rotl(win_r[13], 5'd15))
           ^ rotl(win_r[3], 5'd7) ^ win_r[10];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) data_r <= in_data;
    if (cmd.put) blk_r[pos_r[5:2]][8*(3-pos_r[1:0]) +: 8] <= byte_v;
    if (cmd.load) begin
      win_r <= blk_r;
      a_r <= cv_r[0]; b_r <= cv_r[1]; c_r <= cv_r[2]; d_r <= cv_r[3];
      e_r <= cv_r[4]; f_r <= cv_r[5]; g_r <= cv_r[6]; h_r <= cv_r[7];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= wnew;
      d_r <= c_r;
      c_r <= rotl(b_r, 5'd9);
      b_r <= a_r;
      a_r <= tt1;
      h_r <= g_r;
      g_r <= rotl(f_r, 5'd19);
      f_r <= e_r;
      e_r <= perm0(tt2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      cv_r  <= IV;
      pos_r <= '0;
      msg_r <= '0;
    end else begin
      if (cmd.put) pos_r <= pos_r + 6'd1;
      if (cmd.count) msg_r <= msg_r + 61'd1;
      if (cmd.final_xor) begin
        cv_r[0] <= cv_r[0] ^ a_r; cv_r[1] <= cv_r[1] ^ b_r;
        cv_r[2] <= cv_r[2] ^ c_r; cv_r[3] <= cv_r[3] ^ d_r;
        cv_r[4] <= cv_r[4] ^ e_r; cv_r[5] <= cv_r[5] ^ f_r;
        cv_r[6] <= cv_r[6] ^ g_r; cv_r[7] <= cv_r[7] ^ h_r;
      end
    end
  end

endmodule

`default_nettype wire

[src/sm3_ctrl.sv]
// sm3 controller: byte sequencing, padding, round count and digest output
// depends on sm3_pkg
`timescale 1ns / 1ps
`default_nettype none

module sm3_ctrl import sm3_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_count,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_index,
  output logic            out_done,
  input  wire status_t    st,
  output cmd_t            cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DATA  = 9'b000000010,
    S_PAD   = 9'b000000100,
    S_ZERO  = 9'b000001000,
    S_LEN   = 9'b000010000,
    S_LOAD  = 9'b000100000,
    S_ROUND = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt, ret_r, ret_nxt, after;
  logic [2:0] cnt_r, cnt_nxt, k_r, k_nxt, idx_r, idx_nxt;
  logic       last_r, last_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       in_acc, out_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_acc   = out_valid && out_ready;
  assign out_index = idx_r;
  assign out_done  = (idx_r == 3'd7);

  // where the byte sequence goes after the current byte
  always_comb begin
    unique case (state_r)
      S_DATA:         after = ((k_r + 3'd1) < cnt_r) ? S_DATA : (last_r ? S_PAD : S_IDLE);
      S_PAD, S_ZERO:  after = st.pos_at55 ? S_LEN : S_ZERO;
      S_LEN:          after = (k_r == 3'd7) ? S_OUT : S_LEN;
      default:        after = S_IDLE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    rnd_nxt   = rnd_r;
    cmd       = '0;
    cmd.sel       = SEL_ZERO;
    cmd.byte_k    = k_r;
    cmd.round_idx = rnd_r;
    cmd.out_idx   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.capture = 1'b1;
          cnt_nxt  = (in_count > 3'd4) ? 3'd4 : in_count;
          last_nxt = in_last;
          k_nxt    = '0;
          if (in_count != 3'd0) state_nxt = S_DATA;
          else if (in_last)     state_nxt = S_PAD;
        end
      end
      S_DATA, S_PAD, S_ZERO, S_LEN: begin
        cmd.put = 1'b1;
        unique case (state_r)
          S_DATA:  cmd.sel = SEL_DATA;
          S_PAD:   cmd.sel = SEL_PAD;
          S_LEN:   cmd.sel = SEL_LEN;
          default: cmd.sel = SEL_ZERO;
        endcase
        cmd.count = (state_r == S_DATA);
        k_nxt = (after == state_r) ? k_r + 3'd1 : 3'd0;
        if (st.pos_wrap) begin
          state_nxt = S_LOAD;
          ret_nxt   = after;
        end else begin
          state_nxt = after;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'(ROUNDS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.final_xor = 1'b1;
        idx_nxt   = '0;
        state_nxt = ret_r;
      end
      S_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.restart = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      idx_r   <= '0;
      last_r  <= 1'b0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

endmodule

`default_nettype wire

[src/sm3_hash_engine.sv]
// sm3 hash engine top level: controller plus datapath
// sequence: the word is accepted, then each valid byte is written into the block buffer;
// each full block then runs load, 64 rounds and fold; last word: padding bytes one a cycle
// while no compression runs, plus one or two compressions, then 8 digest words
// a new word is accepted only in idle, after the bytes of the last word and any compression are done
// reset (rst_n, synchronous): chaining value to the initial vector, counters to zero
// depends on sm3_pkg, sm3_if, sm3_ctrl, sm3_datapath
`timescale 1ns / 1ps
`default_nettype none

module sm3_hash_engine import sm3_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  // commands from the sequencer, status back from the datapath
  cmd_t    cmd;
  status_t st;

  sm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_count  (in_ch.byte_count),
    .in_last   (in_ch.last_word),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_index (out_ch.word_index),
    .out_done  (out_ch.digest_done),
    .st        (st),
    .cmd       (cmd)
  );

  // block buffer, schedule window and round state
  sm3_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_ch.data_word),
    .st          (st),
    .digest_word (out_ch.digest_word)
  );

endmodule

`default_nettype wire
